### rtl/iprl_pkg.sv
// shared types and constants for the ipv4 route lookup block
// no dependencies; imported by the controller, the datapath and the top level
package iprl_pkg;

   localparam int REDIRECT_ENTRIES_DEF = 16;
   localparam int MAX_INTERFACES_DEF   = 4;

   localparam int ADDR_W      = 32;
   localparam int CMD_W       = 2;
   localparam int ENTRY_IDX_W = 4;
   localparam int IFACE_W     = 2;
   localparam int NUM_IF_W    = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   // slot index widened far enough to compare against table depths up to 511
   localparam int SLOT_EXT_W  = 9;

   localparam logic [ADDR_W-1:0] ALL_ONES_ADDR = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_IFACES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_GW = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP      = 2'd0,
      CMD_WR_IFACE    = 2'd1,
      CMD_WR_REDIRECT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      LOAD_NONE     = 2'd0,
      LOAD_REDIRECT = 2'd1,
      LOAD_IFACE    = 2'd2,
      LOAD_DEFAULT  = 2'd3
   } load_sel_type;

   // controller to datapath
   typedef struct packed {
      logic         wr_iface;
      logic         wr_redirect;
      logic         start_lookup;
      logic         rdr_advance;
      logic         if_advance;
      load_sel_type load_sel;
   } dp_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic rdr_hit;
      logic rdr_end;
      logic rdr_last;
      logic if_in_range;
      logic if_hit;
      logic if_last;
   } dp_status_type;

endpackage

### rtl/ipv4_route_lookup.sv
// top level of the ipv4 next-hop route lookup
// depends on iprl_pkg, iprl_ctrl and iprl_datapath
//
// one command beat is taken on a clock edge with start high and busy low.
// interface and redirect writes finish on that edge, give no result and leave
// busy low. a lookup keeps busy high while it scans redirect slots (up to
// REDIRECT_ENTRIES, ending on a hit or at the first empty slot). without a
// redirect hit it then checks interfaces (at least one, up to the interfaces
// in use). the scan walks each table one entry a cycle, through the one read
// port of that table. the result beat shows on rsp_valid for exactly one
// cycle, the first cycle with busy low again. the receiver has no way to hold
// it, so it must take every beat as it comes. a new command may be issued
// while that beat is shown. no route gives routed 0, iface 0, first hop 0.
// csr writes are meant for idle periods only.
module ipv4_route_lookup
   import iprl_pkg::*;
#(
   parameter int REDIRECT_ENTRIES = REDIRECT_ENTRIES_DEF,
   parameter int MAX_INTERFACES   = MAX_INTERFACES_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   // command channel
   input  logic                   start,
   output logic                   busy,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [ENTRY_IDX_W-1:0] req_entry_index,
   input  logic [ADDR_W-1:0]      req_dest_addr,
   input  logic [ADDR_W-1:0]      req_next_hop_addr,
   input  logic [ADDR_W-1:0]      req_if_addr,
   input  logic [ADDR_W-1:0]      req_if_mask,
   input  logic [ADDR_W-1:0]      req_if_net_bcast,
   input  logic [ADDR_W-1:0]      req_if_bsd_bcast,
   // result channel
   output logic                   rsp_valid,
   output logic                   rsp_routed,
   output logic [IFACE_W-1:0]     rsp_iface,
   output logic [ADDR_W-1:0]      rsp_first_hop,
   // config registers
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   dp_ctl_type    ctl;
   dp_status_type status;

   // sequencer: decodes the command beat and steps the scans
   iprl_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .status  (status),
      .ctl     (ctl),
      .busy    (busy)
   );

   // tables, compare logic and result registers
   iprl_datapath #(
      .REDIRECT_ENTRIES (REDIRECT_ENTRIES),
      .MAX_INTERFACES   (MAX_INTERFACES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .status            (status),
      .req_entry_index   (req_entry_index),
      .req_dest_addr     (req_dest_addr),
      .req_next_hop_addr (req_next_hop_addr),
      .req_if_addr       (req_if_addr),
      .req_if_mask       (req_if_mask),
      .req_if_net_bcast  (req_if_net_bcast),
      .req_if_bsd_bcast  (req_if_bsd_bcast),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_routed        (rsp_routed),
      .rsp_iface         (rsp_iface),
      .rsp_first_hop     (rsp_first_hop)
   );

endmodule

### rtl/iprl_ctrl.sv
// sequencer for the route lookup: redirect scan, interface scan, result select
// depends on iprl_pkg
module iprl_ctrl
   import iprl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CMD_W-1:0]  req_cmd,
   input  dp_status_type     status,
   output dp_ctl_type        ctl,
   output logic              busy
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RDR  = 3'b010,
      ST_IF   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      ctl.wr_iface     = 1'b0;
      ctl.wr_redirect  = 1'b0;
      ctl.start_lookup = 1'b0;
      ctl.rdr_advance  = 1'b0;
      ctl.if_advance   = 1'b0;
      ctl.load_sel     = LOAD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_cmd)
                  CMD_LOOKUP: begin
                     ctl.start_lookup = 1'b1;
                     state_in         = ST_RDR;
                  end
                  CMD_WR_IFACE: begin
                     ctl.wr_iface = 1'b1;
                  end
                  CMD_WR_REDIRECT: begin
                     ctl.wr_redirect = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RDR: begin
            priority if (status.rdr_hit) begin
               ctl.load_sel = LOAD_REDIRECT;
               state_in     = ST_IDLE;
            end else if (status.rdr_end || status.rdr_last) begin
               state_in = ST_IF;
            end else begin
               ctl.rdr_advance = 1'b1;
            end
         end
         ST_IF: begin
            priority if (!status.if_in_range) begin
               ctl.load_sel = LOAD_DEFAULT;
               state_in     = ST_IDLE;
            end else if (status.if_hit) begin
               ctl.load_sel = LOAD_IFACE;
               state_in     = ST_IDLE;
            end else if (status.if_last) begin
               ctl.load_sel = LOAD_DEFAULT;
               state_in     = ST_IDLE;
            end else begin
               ctl.if_advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/iprl_datapath.sv
// tables, config registers, entry compare and result registers of the lookup
// depends on iprl_pkg; driven by iprl_ctrl
module iprl_datapath
   import iprl_pkg::*;
#(
   parameter int REDIRECT_ENTRIES = REDIRECT_ENTRIES_DEF,
   parameter int MAX_INTERFACES   = MAX_INTERFACES_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  dp_ctl_type             ctl,
   output dp_status_type          status,
   input  logic [ENTRY_IDX_W-1:0] req_entry_index,
   input  logic [ADDR_W-1:0]      req_dest_addr,
   input  logic [ADDR_W-1:0]      req_next_hop_addr,
   input  logic [ADDR_W-1:0]      req_if_addr,
   input  logic [ADDR_W-1:0]      req_if_mask,
   input  logic [ADDR_W-1:0]      req_if_net_bcast,
   input  logic [ADDR_W-1:0]      req_if_bsd_bcast,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output logic                   rsp_valid,
   output logic                   rsp_routed,
   output logic [IFACE_W-1:0]     rsp_iface,
   output logic [ADDR_W-1:0]      rsp_first_hop
);

   localparam int RDR_IDX_W = (REDIRECT_ENTRIES > 1) ? $clog2(REDIRECT_ENTRIES) : 1;
   localparam int IF_IDX_W  = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
   localparam int IF_CNT_W  = $clog2(MAX_INTERFACES + 1);

   // config registers
   logic [NUM_IF_W-1:0] num_ifaces_ff;
   logic [ADDR_W-1:0]   default_gw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ifaces_ff <= '0;
         default_gw_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_IFACES: num_ifaces_ff <= csr_wr_data[NUM_IF_W-1:0];
            CSR_DEFAULT_GW: default_gw_ff <= csr_wr_data[ADDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // write slot decode
   logic [SLOT_EXT_W-1:0] slot_ext;
   logic                  rdr_wr;
   logic                  if_wr;
   logic [RDR_IDX_W-1:0]  rdr_wr_idx;
   logic [IF_IDX_W-1:0]   if_wr_idx;

   assign slot_ext   = SLOT_EXT_W'(req_entry_index);
   assign rdr_wr     = ctl.wr_redirect && (slot_ext < SLOT_EXT_W'(REDIRECT_ENTRIES));
   assign if_wr      = ctl.wr_iface && (slot_ext < SLOT_EXT_W'(MAX_INTERFACES));
   assign rdr_wr_idx = slot_ext[RDR_IDX_W-1:0];
   assign if_wr_idx  = slot_ext[IF_IDX_W-1:0];

   // lookup address and scan pointers
   logic [ADDR_W-1:0]    dst_ff;
   logic [RDR_IDX_W-1:0] rdr_ptr_ff;
   logic [RDR_IDX_W-1:0] rdr_ptr_in;
   logic [IF_IDX_W-1:0]  if_ptr_ff;
   logic [IF_IDX_W-1:0]  if_ptr_in;
   logic                 rdr_last;

   assign rdr_last = (rdr_ptr_ff == RDR_IDX_W'(REDIRECT_ENTRIES - 1));

   always_comb begin
      rdr_ptr_in = rdr_ptr_ff;
      if_ptr_in  = if_ptr_ff;
      if (ctl.start_lookup) begin
         rdr_ptr_in = '0;
         if_ptr_in  = '0;
      end else begin
         if (ctl.rdr_advance) begin
            rdr_ptr_in = rdr_last ? '0 : rdr_ptr_ff + 1'b1;
         end
         if (ctl.if_advance) begin
            if_ptr_in = if_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdr_ptr_ff <= '0;
         if_ptr_ff  <= '0;
      end else begin
         rdr_ptr_ff <= rdr_ptr_in;
         if_ptr_ff  <= if_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start_lookup) begin
         dst_ff <= req_dest_addr;
      end
   end

   // redirect table, registered read at the next scan slot
   logic [ADDR_W-1:0]           rdr_dest_mem [REDIRECT_ENTRIES];
   logic [ADDR_W-1:0]           rdr_hop_mem  [REDIRECT_ENTRIES];
   logic [REDIRECT_ENTRIES-1:0] rdr_vld_ff;
   logic [ADDR_W-1:0]           rdr_dest_q;
   logic [ADDR_W-1:0]           rdr_hop_q;
   logic                        rdr_vld_q;

   always_ff @(posedge clock) begin
      if (rdr_wr) begin
         rdr_dest_mem[rdr_wr_idx] <= req_dest_addr;
         rdr_hop_mem[rdr_wr_idx]  <= req_next_hop_addr;
      end
      rdr_dest_q <= rdr_dest_mem[rdr_ptr_in];
      rdr_hop_q  <= rdr_hop_mem[rdr_ptr_in];
   end

   // an unwritten slot reads as a zero destination
   always_ff @(posedge clock) begin
      if (reset) begin
         rdr_vld_ff <= '0;
         rdr_vld_q  <= 1'b0;
      end else begin
         if (rdr_wr) begin
            rdr_vld_ff[rdr_wr_idx] <= 1'b1;
         end
         rdr_vld_q <= rdr_vld_ff[rdr_ptr_in];
      end
   end

   // interface table, registered read
   logic [ADDR_W-1:0] if_addr_mem  [MAX_INTERFACES];
   logic [ADDR_W-1:0] if_mask_mem  [MAX_INTERFACES];
   logic [ADDR_W-1:0] if_net_mem   [MAX_INTERFACES];
   logic [ADDR_W-1:0] if_bsd_mem   [MAX_INTERFACES];
   logic [ADDR_W-1:0] if_addr_q;
   logic [ADDR_W-1:0] if_mask_q;
   logic [ADDR_W-1:0] if_net_q;
   logic [ADDR_W-1:0] if_bsd_q;

   always_ff @(posedge clock) begin
      if (if_wr) begin
         if_addr_mem[if_wr_idx] <= req_if_addr;
         if_mask_mem[if_wr_idx] <= req_if_mask;
         if_net_mem[if_wr_idx]  <= req_if_net_bcast;
         if_bsd_mem[if_wr_idx]  <= req_if_bsd_bcast;
      end
      if_addr_q <= if_addr_mem[if_ptr_in];
      if_mask_q <= if_mask_mem[if_ptr_in];
      if_net_q  <= if_net_mem[if_ptr_in];
      if_bsd_q  <= if_bsd_mem[if_ptr_in];
   end

   // entry compare
   logic [IF_CNT_W-1:0] if_used;
   logic [IF_CNT_W-1:0] if_ptr_ext;
   logic                rdr_zero;

   always_comb begin
      if (32'(num_ifaces_ff) > MAX_INTERFACES) begin
         if_used = IF_CNT_W'(MAX_INTERFACES);
      end else begin
         if_used = IF_CNT_W'(num_ifaces_ff);
      end
   end

   assign if_ptr_ext = IF_CNT_W'(if_ptr_ff);
   assign rdr_zero   = !rdr_vld_q || (rdr_dest_q == '0);

   assign status.rdr_hit     = !rdr_zero && (rdr_dest_q == dst_ff);
   assign status.rdr_end     = rdr_zero;
   assign status.rdr_last    = rdr_last;
   assign status.if_in_range = (if_ptr_ext < if_used);
   assign status.if_hit      = ((if_addr_q & if_mask_q) == (dst_ff & if_mask_q))
                             || (dst_ff == if_net_q)
                             || (dst_ff == if_bsd_q)
                             || (dst_ff == ALL_ONES_ADDR);
   assign status.if_last     = ((if_ptr_ext + 1'b1) == if_used);

   // result registers
   logic               rsp_valid_ff;
   logic               rsp_routed_ff;
   logic [IFACE_W-1:0] rsp_iface_ff;
   logic [ADDR_W-1:0]  rsp_hop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (ctl.load_sel != LOAD_NONE);
      end
   end

   always_ff @(posedge clock) begin
      unique case (ctl.load_sel)
         LOAD_REDIRECT: begin
            rsp_routed_ff <= 1'b1;
            rsp_iface_ff  <= '0;
            rsp_hop_ff    <= rdr_hop_q;
         end
         LOAD_IFACE: begin
            rsp_routed_ff <= 1'b1;
            rsp_iface_ff  <= IFACE_W'(if_ptr_ff);
            rsp_hop_ff    <= dst_ff;
         end
         LOAD_DEFAULT: begin
            rsp_routed_ff <= (default_gw_ff != '0);
            rsp_iface_ff  <= '0;
            rsp_hop_ff    <= default_gw_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_routed    = rsp_routed_ff;
   assign rsp_iface     = rsp_iface_ff;
   assign rsp_first_hop = rsp_hop_ff;

endmodule
